@@ hdl/tmn_pkg.sv @@
// Shared types and constants of the token mutex node.
`default_nettype none
package tmn_pkg;

  localparam int NODES      = 8;
  localparam int COUNT_BITS = 16;
  localparam int NODE_W     = $clog2(NODES);
  localparam int FIELD_W    = 3;
  localparam int OWN        = NODES - 1;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [NODE_W-1:0]     addr_t;
  typedef logic [FIELD_W-1:0]    node_t;

  typedef enum logic [1:0] {
    MODE_LOCAL  = 2'd0,
    MODE_REMOTE = 2'd1,
    MODE_TOKEN  = 2'd2,
    MODE_LEAVE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_BCAST = 2'd0,
    ACT_TOKEN = 2'd1,
    ACT_ENTER = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    PH_OUTSIDE = 2'd0,
    PH_WAITING = 2'd1,
    PH_INSIDE  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOCAL,
    ST_REMOTE,
    ST_TOK_RD,
    ST_ENTER,
    ST_SCAN,
    ST_SEND_RD,
    ST_SEND
  } state_t;

  typedef struct packed {
    mode_t  mode;
    node_t  node;
    count_t count;
    logic   last;
  } in_item_t;

  typedef struct packed {
    action_t action;
    node_t   dest;
    node_t   entry_node;
    count_t  count;
    logic    last;
  } res_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    count_t wdata;
    logic   re;
    addr_t  raddr;
  } mem_req_t;

endpackage
`default_nettype wire

@@ hdl/tmn_cnt_mem.sv @@
// Count memory: one write and one registered read port, per-entry valid bits.
`default_nettype none
module tmn_cnt_mem
  import tmn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mem_req_t req,
  output count_t        rdata
);

  count_t           mem [NODES];
  logic [NODES-1:0] vld;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= vld[req.raddr] ? mem[req.raddr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.we) begin
      vld[req.waddr] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ hdl/tmn_ctrl.sv @@
// Sequencer: read-modify-write of the count memories, token scan and send.
`default_nettype none
module tmn_ctrl
  import tmn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     cfg_we,
  input  wire logic     cfg_bit,
  output mem_req_t      req_port,
  input  wire count_t   req_rdata,
  output mem_req_t      srv_port,
  input  wire count_t   srv_rdata,
  output logic          emit,
  output res_t          res,
  input  wire logic     can_emit
);

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   token_held, token_held_next;
  node_t  node_r, node_r_next;
  count_t cnt_r, cnt_r_next;
  addr_t  idx, idx_next;
  addr_t  best_idx, best_idx_next;
  count_t best_cnt, best_cnt_next;
  logic   best_found, best_found_next;
  node_t  dest, dest_next;

  addr_t  own_addr;
  addr_t  in_addr;
  addr_t  p_idx;
  count_t req_inc;
  count_t diff;
  logic   pending;
  logic   take;

  assign own_addr = NODE_W'(OWN);
  assign in_addr  = NODE_W'(in_item.node);
  assign p_idx    = idx - 1'b1;
  assign req_inc  = req_rdata + 1'b1;
  assign diff     = req_rdata - srv_rdata;
  assign pending  = (diff != '0) && !diff[COUNT_BITS-1];
  assign take     = pending && (!best_found || (srv_rdata < best_cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_OUTSIDE;
      token_held <= 1'b0;
      best_found <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      token_held <= cfg_we ? cfg_bit : token_held_next;
      best_found <= best_found_next;
    end
  end

  always_ff @(posedge clk) begin
    node_r   <= node_r_next;
    cnt_r    <= cnt_r_next;
    idx      <= idx_next;
    best_idx <= best_idx_next;
    best_cnt <= best_cnt_next;
    dest     <= dest_next;
  end

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    token_held_next = token_held;
    node_r_next     = node_r;
    cnt_r_next      = cnt_r;
    idx_next        = idx;
    best_idx_next   = best_idx;
    best_cnt_next   = best_cnt;
    best_found_next = best_found;
    dest_next       = dest;
    req_port        = '0;
    srv_port        = '0;
    emit            = 1'b0;
    res             = '0;
    in_ready        = (state == ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          node_r_next = in_item.node;
          cnt_r_next  = in_item.count;
          unique case (in_item.mode)
            MODE_LOCAL: begin
              if (phase == PH_OUTSIDE) begin
                req_port.re    = 1'b1;
                req_port.raddr = own_addr;
                srv_port.re    = 1'b1;
                srv_port.raddr = own_addr;
                state_next     = ST_LOCAL;
              end
            end
            MODE_REMOTE: begin
              if (32'(in_item.node) < OWN) begin
                req_port.re    = 1'b1;
                req_port.raddr = in_addr;
                state_next     = ST_REMOTE;
              end
            end
            MODE_TOKEN: begin
              if (32'(in_item.node) < NODES) begin
                srv_port.we    = 1'b1;
                srv_port.waddr = in_addr;
                srv_port.wdata = in_item.count;
              end
              if (in_item.last) begin
                token_held_next = 1'b1;
                if (phase == PH_WAITING) begin
                  state_next = ST_TOK_RD;
                end
              end
            end
            MODE_LEAVE: begin
              if (phase == PH_INSIDE && token_held) begin
                phase_next      = PH_OUTSIDE;
                idx_next        = '0;
                best_found_next = 1'b0;
                state_next      = ST_SCAN;
              end
            end
          endcase
        end
      end

      ST_LOCAL: begin
        if (can_emit) begin
          emit           = 1'b1;
          res.last       = 1'b1;
          req_port.we    = 1'b1;
          req_port.waddr = own_addr;
          req_port.wdata = req_inc;
          if (token_held) begin
            srv_port.we    = 1'b1;
            srv_port.waddr = own_addr;
            srv_port.wdata = srv_rdata + 1'b1;
            phase_next     = PH_INSIDE;
            res.action     = ACT_ENTER;
          end else begin
            phase_next     = PH_WAITING;
            res.action     = ACT_BCAST;
            res.entry_node = FIELD_W'(OWN);
            res.count      = req_inc;
          end
          state_next = ST_IDLE;
        end
      end

      ST_REMOTE: begin
        if (cnt_r > req_rdata) begin
          req_port.we    = 1'b1;
          req_port.waddr = NODE_W'(node_r);
          req_port.wdata = cnt_r;
        end
        if (phase == PH_OUTSIDE && token_held) begin
          dest_next  = node_r;
          idx_next   = '0;
          state_next = ST_SEND_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_TOK_RD: begin
        srv_port.re    = 1'b1;
        srv_port.raddr = own_addr;
        state_next     = ST_ENTER;
      end

      ST_ENTER: begin
        if (can_emit) begin
          emit           = 1'b1;
          res.action     = ACT_ENTER;
          res.last       = 1'b1;
          srv_port.we    = 1'b1;
          srv_port.waddr = own_addr;
          srv_port.wdata = srv_rdata + 1'b1;
          phase_next     = PH_INSIDE;
          state_next     = ST_IDLE;
        end
      end

      ST_SCAN: begin
        if (idx != own_addr) begin
          req_port.re    = 1'b1;
          req_port.raddr = idx;
          srv_port.re    = 1'b1;
          srv_port.raddr = idx;
        end
        if (idx != '0 && take) begin
          best_found_next = 1'b1;
          best_idx_next   = p_idx;
          best_cnt_next   = srv_rdata;
        end
        idx_next = idx + 1'b1;
        if (idx == own_addr) begin
          idx_next = '0;
          if (best_found_next) begin
            dest_next  = FIELD_W'(best_idx_next);
            state_next = ST_SEND_RD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end

      ST_SEND_RD: begin
        srv_port.re    = 1'b1;
        srv_port.raddr = idx;
        state_next     = ST_SEND;
      end

      ST_SEND: begin
        if (can_emit) begin
          emit           = 1'b1;
          res.action     = ACT_TOKEN;
          res.dest       = dest;
          res.entry_node = FIELD_W'(idx);
          res.count      = srv_rdata;
          res.last       = (idx == own_addr);
          if (idx == own_addr) begin
            token_held_next = 1'b0;
            state_next      = ST_IDLE;
          end else begin
            srv_port.re    = 1'b1;
            srv_port.raddr = idx + 1'b1;
            idx_next       = idx + 1'b1;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  a_send_drops_token: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND && emit && idx == own_addr) |=> !token_held)
    else $error("token still held after last entry sent");

  a_single_result_last: assert property (@(posedge clk) disable iff (rst)
    (emit && res.action != ACT_TOKEN) |-> res.last)
    else $error("single result not marked last");

  a_no_req_collision: assert property (@(posedge clk) disable iff (rst)
    !(req_port.we && req_port.re && req_port.waddr == req_port.raddr))
    else $error("request memory read and write hit same entry");

  a_send_no_srv_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND || state == ST_SCAN) |-> !srv_port.we)
    else $error("served count written during scan or send");

endmodule
`default_nettype wire

@@ hdl/token_mutex_node_unit.sv @@
// Top level of the token mutex node: stream ports, memories, output register.
// One node of token-based mutual exclusion; its own index is NODES-1. Request
// and served counts live in two small memories with registered reads, both
// cleared by reset through per-entry valid bits, so no clearing pass is needed.
// Items are handled one at a time: a local request, a remote request (which
// may also send the token), a token entry (which may complete a wait), and a
// leave, which runs the requester scan and then, if a requester waits, the
// token send. The scan walks the single read port of each memory one entry
// per cycle and the send one entry per result; results are one per cycle
// while the output side is ready. Each result sits in an output register, so
// a new item is taken while the last result waits.
`default_nettype none
module token_mutex_node_unit
  import tmn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,       // start_with_token
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // node[2:0], count[18:3], zero pad
  input  wire logic [1:0]  s_axis_tuser,   // mode
  input  wire logic        s_axis_tlast,   // last_entry
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // dest_node[2:0], entry_node[5:3],
                                           // entry_count[21:6], zero pad
  output logic [1:0]       m_axis_tuser,   // action
  output logic             m_axis_tlast    // last_of_run
);

  in_item_t in_item;
  mem_req_t req_port, srv_port;
  count_t   req_rdata, srv_rdata;
  logic     emit, can_emit;
  res_t     res, out_r;
  logic     out_valid;

  assign cfg_ready    = 1'b1;
  assign in_item.mode  = mode_t'(s_axis_tuser);
  assign in_item.node  = s_axis_tdata[FIELD_W-1:0];
  assign in_item.count = s_axis_tdata[FIELD_W+COUNT_BITS-1:FIELD_W];
  assign in_item.last  = s_axis_tlast;

  tmn_cnt_mem u_req_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (req_port),
    .rdata (req_rdata)
  );

  tmn_cnt_mem u_srv_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (srv_port),
    .rdata (srv_rdata)
  );

  tmn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .cfg_we    (cfg_valid),
    .cfg_bit   (cfg_data),
    .req_port  (req_port),
    .req_rdata (req_rdata),
    .srv_port  (srv_port),
    .srv_rdata (srv_rdata),
    .emit      (emit),
    .res       (res),
    .can_emit  (can_emit)
  );

  assign can_emit = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_emit) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit && emit) begin
      out_r <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_r.action;
  assign m_axis_tlast  = out_r.last;
  assign m_axis_tdata  = {2'b00, out_r.count, out_r.entry_node, out_r.dest};

endmodule
`default_nettype wire
